// File: src/stc_pkg.sv
// shared types, constants and arithmetic helpers for the stopwatch countdown timer
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

	localparam int SLOT_COUNT_DEF = 3;

	localparam int FUNC_W   = 4;
	localparam int SLOT_IW  = 2;
	localparam int HOUR_W   = 7;
	localparam int MIN_W    = 6;
	localparam int SEC_W    = 6;
	localparam int SUB_W    = 8;
	localparam int HUND_W   = 7;
	localparam int DIGIT_W  = 4;
	localparam int N_DIGITS = 6;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 56;
	localparam int CFG_IW   = 2;

	localparam logic [HOUR_W-1:0] HOUR_MAX_INC = 7'd99;
	localparam logic [MIN_W-1:0]  MIN_MAX      = 6'd59;
	localparam logic [SEC_W-1:0]  SEC_MAX      = 6'd59;
	localparam logic [SUB_W-1:0]  SUB_MAX      = 8'd255;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK  = 4'd0,
		FN_START = 4'd1,
		FN_STOP  = 4'd2,
		FN_CLEAR = 4'd3,
		FN_SAVE  = 4'd4,
		FN_INC_H = 4'd5,
		FN_INC_M = 4'd6,
		FN_INC_S = 4'd7,
		FN_READ  = 4'd8
	} func_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_COUNT_DOWN = 2'd0,
		REG_DISP_EN    = 2'd1,
		REG_DISP_FMT   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic count_down;
		logic display_enable;
		logic display_format;
	} cfg_t;

	typedef struct packed {
		logic running;
		logic halted;
	} status_t;

	typedef struct packed {
		logic                             expired_event;
		logic                             display_update;
		logic [N_DIGITS-1:0][DIGIT_W-1:0] digit;
		logic [HUND_W-1:0]                hundredths;
		logic [SEC_W-1:0]                 second;
		logic [MIN_W-1:0]                 minute;
		logic [HOUR_W-1:0]                hour;
	} res_t;

	// floor(v/10) for v below 128
	function automatic logic [DIGIT_W-1:0] tens_of(input logic [HOUR_W-1:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'd205;
		return p[14:11];
	endfunction

	function automatic logic [DIGIT_W-1:0] units_of(input logic [HOUR_W-1:0] v);
		logic [DIGIT_W-1:0] t;
		logic [HOUR_W-1:0]  r;
		t = tens_of(v);
		r = v - 7'(7'(t) * 7'd10);
		return r[DIGIT_W-1:0];
	endfunction

	// floor(sub*39/100)
	function automatic logic [HUND_W-1:0] hund_of(input logic [SUB_W-1:0] sub);
		logic [25:0] p;
		p = 26'(sub) * 26'd204477;
		return p[25:19];
	endfunction

	// floor(sub*39/1000), tens digit of the hundredths
	function automatic logic [DIGIT_W-1:0] hund_tens(input logic [SUB_W-1:0] sub);
		logic [23:0] p;
		p = 24'(sub) * 24'd40895;
		return p[23:20];
	endfunction

	// (h+1) mod 24 for h up to 99
	function automatic logic [HOUR_W-1:0] hour_inc24(input logic [HOUR_W-1:0] h);
		logic [HOUR_W-1:0] v;
		v = h + 7'd1;
		if (v >= 7'd96) begin
			v = v - 7'd96;
		end else if (v >= 7'd72) begin
			v = v - 7'd72;
		end else if (v >= 7'd48) begin
			v = v - 7'd48;
		end else if (v >= 7'd24) begin
			v = v - 7'd24;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// File: src/stc_digits.sv
// display digit formatter for the live count
`timescale 1ns / 1ps
`default_nettype none

module stc_digits
	import stc_pkg::*;
(
	input  wire logic                             enable,
	input  wire logic                             fmt,
	input  wire logic [HOUR_W-1:0]                hour,
	input  wire logic [MIN_W-1:0]                 minute,
	input  wire logic [SEC_W-1:0]                 second,
	input  wire logic [SUB_W-1:0]                 sub,
	output logic      [N_DIGITS-1:0][DIGIT_W-1:0] digit
);

	logic [HOUR_W-1:0]  min_x;
	logic [HOUR_W-1:0]  sec_x;
	logic [DIGIT_W-1:0] ht;
	logic [HUND_W-1:0]  hu;
	logic [HUND_W-1:0]  hu_units;

	assign min_x    = 7'(minute);
	assign sec_x    = 7'(second);
	assign ht       = hund_tens(sub);
	assign hu       = hund_of(sub);
	assign hu_units = hu - 7'(7'(ht) * 7'd10);

	always_comb begin
		digit = '0;
		if (enable) begin
			if (fmt) begin
				digit[5] = tens_of(min_x);
				digit[4] = units_of(min_x);
				digit[3] = tens_of(sec_x);
				digit[2] = units_of(sec_x);
				digit[1] = ht;
				digit[0] = hu_units[DIGIT_W-1:0];
			end else begin
				digit[5] = tens_of(hour);
				digit[4] = units_of(hour);
				digit[3] = tens_of(min_x);
				digit[2] = units_of(min_x);
				digit[1] = tens_of(sec_x);
				digit[0] = units_of(sec_x);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/stc_state.sv
// slot stores, run state and single-pass command execution
`timescale 1ns / 1ps
`default_nettype none

module stc_state
	import stc_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [SLOT_IW-1:0] slot,
	input  wire cfg_t               cfg,
	output res_t                    res,
	output status_t                 status
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [HOUR_W-1:0] hour_q [SLOT_COUNT];
	logic [MIN_W-1:0]  min_q  [SLOT_COUNT];
	logic [SEC_W-1:0]  sec_q  [SLOT_COUNT];
	logic [SUB_W-1:0]  sub_q  [SLOT_COUNT];
	logic [HOUR_W-1:0] hour_n [SLOT_COUNT];
	logic [MIN_W-1:0]  min_n  [SLOT_COUNT];
	logic [SEC_W-1:0]  sec_n  [SLOT_COUNT];
	logic [SUB_W-1:0]  sub_n  [SLOT_COUNT];
	logic              running_q;
	logic              halted_q;
	logic              running_n;
	logic              halted_n;
	logic              expired;
	logic              upd;
	logic              ok;
	logic [SLOT_W-1:0] sidx;
	logic [N_DIGITS-1:0][DIGIT_W-1:0] digit;

	assign ok   = (4'(slot) < 4'(SLOT_COUNT));
	assign sidx = SLOT_W'(slot);
	assign upd  = (func == FN_TICK) && running_q && cfg.display_enable;

	always_comb begin
		logic [HOUR_W-1:0] h;
		logic [MIN_W-1:0]  m;
		logic [SEC_W-1:0]  s;
		logic [SUB_W-1:0]  t;
		hour_n    = hour_q;
		min_n     = min_q;
		sec_n     = sec_q;
		sub_n     = sub_q;
		running_n = running_q;
		halted_n  = halted_q;
		expired   = 1'b0;
		h = hour_q[0];
		m = min_q[0];
		s = sec_q[0];
		t = sub_q[0];
		case (func)
			FN_TICK: begin
				if (running_q) begin
					if (!cfg.count_down) begin
						t = t + 8'd1;
						if (t == '0) begin
							s = (s == SEC_MAX) ? '0 : s + 6'd1;
							if (s == '0) begin
								m = (m == MIN_MAX) ? '0 : m + 6'd1;
								if (m == '0) begin
									h = hour_inc24(h);
								end
							end
						end
					end else if (!halted_q) begin
						if ((t != '0) || (s != '0) || (m != '0) || (h != '0)) begin
							t = t - 8'd1;
							if (t == SUB_MAX) begin
								if (s == '0) begin
									s = SEC_MAX;
									if (m == '0) begin
										m = MIN_MAX;
										if (h != '0) begin
											h = h - 7'd1;
										end
									end else begin
										m = m - 6'd1;
									end
								end else begin
									s = s - 6'd1;
								end
							end
						end else begin
							halted_n = 1'b1;
							expired  = 1'b1;
						end
					end
					hour_n[0] = h;
					min_n[0]  = m;
					sec_n[0]  = s;
					sub_n[0]  = t;
				end
			end
			FN_START: begin
				halted_n  = 1'b0;
				running_n = 1'b1;
			end
			FN_STOP: begin
				running_n = 1'b0;
			end
			FN_CLEAR: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					hour_n[i] = '0;
					min_n[i]  = '0;
					sec_n[i]  = '0;
					sub_n[i]  = '0;
				end
				running_n = 1'b0;
				halted_n  = 1'b1;
			end
			FN_SAVE: begin
				if (ok && (sidx != '0)) begin
					hour_n[sidx] = hour_q[0];
					min_n[sidx]  = min_q[0];
					sec_n[sidx]  = sec_q[0];
					sub_n[sidx]  = sub_q[0];
				end
			end
			FN_INC_H: begin
				if (ok) begin
					hour_n[sidx] = (hour_q[sidx] >= HOUR_MAX_INC) ? '0 : hour_q[sidx] + 7'd1;
				end
			end
			FN_INC_M: begin
				if (ok) begin
					min_n[sidx] = (min_q[sidx] >= MIN_MAX) ? '0 : min_q[sidx] + 6'd1;
				end
			end
			FN_INC_S: begin
				if (ok) begin
					sec_n[sidx] = (sec_q[sidx] >= SEC_MAX) ? '0 : sec_q[sidx] + 6'd1;
				end
			end
			default: begin
			end
		endcase
	end

	stc_digits u_digits (
		.enable (upd),
		.fmt    (cfg.display_format),
		.hour   (hour_n[0]),
		.minute (min_n[0]),
		.second (sec_n[0]),
		.sub    (sub_n[0]),
		.digit  (digit)
	);

	always_comb begin
		res                = '0;
		res.digit          = digit;
		res.display_update = upd;
		res.expired_event  = expired;
		if (ok) begin
			res.hour       = hour_n[sidx];
			res.minute     = min_n[sidx];
			res.second     = sec_n[sidx];
			res.hundredths = hund_of(sub_n[sidx]);
		end
	end

	assign status.running = running_q;
	assign status.halted  = halted_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				hour_q[i] <= '0;
				min_q[i]  <= '0;
				sec_q[i]  <= '0;
				sub_q[i]  <= '0;
			end
			running_q <= 1'b0;
			halted_q  <= 1'b1;
		end else if (advance) begin
			hour_q    <= hour_n;
			min_q     <= min_n;
			sec_q     <= sec_n;
			sub_q     <= sub_n;
			running_q <= running_n;
			halted_q  <= halted_n;
		end
	end

endmodule

`default_nettype wire

// File: src/stopwatch_countdown_timer.sv
// stopwatch and countdown timer top level: input register, command unit, output register
// from input accept to output valid a word passes the input register, then the result register
// throughput: one word per cycle while the result side takes words, set by the single-pass update of the slot registers
// the input register drains into the result register whenever that register is empty or taken
// reset: slots zero, timer stopped, countdown halted, configuration registers zero
// configuration writes take effect at once; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module stopwatch_countdown_timer
	import stc_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [IN_W-1:0]   s_axis_tdata,   // func[3:0], slot[5:4], zero fill
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// hour[6:0], minute[12:7], second[18:13], hundredths[25:19], digit5[29:26],
	// digit4[33:30], digit3[37:34], digit2[41:38], digit1[45:42], digit0[49:46],
	// display_update[50], expired_event[51], zero fill
	output logic [OUT_W-1:0]       m_axis_tdata,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic              cfg_data
);

	logic               valid_s1;
	logic [FUNC_W-1:0]  func_s1;
	logic [SLOT_IW-1:0] slot_s1;
	logic               out_valid_q;
	res_t               out_q;
	res_t               res;
	status_t            status;
	cfg_t               cfg_q;
	logic               advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;

	// input word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1 <= s_axis_tdata[FUNC_W-1:0];
			slot_s1 <= s_axis_tdata[FUNC_W+SLOT_IW-1:FUNC_W];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COUNT_DOWN: cfg_q.count_down     <= cfg_data;
				REG_DISP_EN:    cfg_q.display_enable <= cfg_data;
				REG_DISP_FMT:   cfg_q.display_format <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	stc_state #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.func    (func_s1),
		.slot    (slot_s1),
		.cfg     (cfg_q),
		.res     (res),
		.status  (status)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_axis_tdata = {4'b0, out_q.expired_event, out_q.display_update,
		out_q.digit[0], out_q.digit[1], out_q.digit[2], out_q.digit[3],
		out_q.digit[4], out_q.digit[5], out_q.hundredths, out_q.second,
		out_q.minute, out_q.hour};

	a_expire_halts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.expired_event |=> status.halted)
		else $error("expiry did not halt the countdown");

	a_expire_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res.expired_event |-> cfg_q.count_down && !status.halted && status.running)
		else $error("expiry outside a running countdown");

	a_update_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res.display_update |-> (func_s1 == FN_TICK) && status.running && cfg_q.display_enable)
		else $error("display refresh without a running tick");

	a_clear_stops: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (func_s1 == FN_CLEAR) |=> !status.running && status.halted)
		else $error("clear left the timer running");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// self-checking bench for the stopwatch countdown timer: command table, then random traffic
`timescale 1ns / 1ps

module testbench;
	import stc_pkg::*;

	localparam int SLOTS = SLOT_COUNT_DEF;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 219;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [FUNC_W-1:0] FN_ODD_LO = 4'd9;
	localparam logic [FUNC_W-1:0] FN_ODD_HI = 4'd15;
	localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

	typedef enum logic [1:0] {KNOWN_NONE, KNOWN_ZERO, KNOWN_EXPIRY} known_t;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_BLOCKS} rx_mode_t;

	typedef struct packed {
		logic [HOUR_W-1:0]                hour;
		logic [MIN_W-1:0]                 minute;
		logic [SEC_W-1:0]                 second;
		logic [HUND_W-1:0]                hund;
		logic [N_DIGITS-1:0][DIGIT_W-1:0] digit;
		logic                             upd;
		logic                             expd;
	} timer_word_t;

	typedef struct packed {
		logic              apply;
		cfg_t              cfg;
		logic [FUNC_W-1:0] fn;
		logic [1:0]        sl;
		known_t            known;
	} cmd_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic              cfg_data = 1'b0;

	// timer state mirror
	logic [HOUR_W-1:0] hr_st [SLOTS];
	logic [MIN_W-1:0]  mn_st [SLOTS];
	logic [SEC_W-1:0]  sc_st [SLOTS];
	logic [SUB_W-1:0]  sb_st [SLOTS];
	logic              run_q;
	logic              halted_q;
	cfg_t              cfg_q;

	timer_word_t expected_words[$];
	cmd_row_t    cmd_rows[$];
	known_t      cur_known = KNOWN_NONE;
	timer_word_t pred_w, got_w, exp_w;
	int          errors = 0;
	int          burst_left = 0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;
	logic [3:0]  rx_phase = '0;

	stopwatch_countdown_timer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int hund_value(input logic [SUB_W-1:0] sub);
		return (int'(sub) * 39) / 100;
	endfunction

	function automatic void timer_reset();
		for (int i = 0; i < SLOTS; i++) begin
			hr_st[i] = '0;
			mn_st[i] = '0;
			sc_st[i] = '0;
			sb_st[i] = '0;
		end
		run_q = 1'b0;
		halted_q = 1'b1;
	endfunction

	function automatic timer_word_t timer_step(input logic [FUNC_W-1:0] fn,
			input logic [1:0] sl);
		timer_word_t w;
		logic ok;
		int h, m, s, t, a, b, c;
		w = '0;
		ok = (int'(sl) < SLOTS);
		case (fn)
			FN_TICK: begin
				if (run_q) begin
					h = hr_st[0];
					m = mn_st[0];
					s = sc_st[0];
					t = sb_st[0];
					if (!cfg_q.count_down) begin
						t = (t + 1) % 256;
						if (t == 0) begin
							s = (s + 1) % 60;
							if (s == 0) begin
								m = (m + 1) % 60;
								if (m == 0) h = (h + 1) % 24;
							end
						end
					end else if (!halted_q) begin
						if (t != 0 || s != 0 || m != 0 || h != 0) begin
							t = (t + 255) % 256;
							if (t == 255) begin
								if (s == 0) begin
									s = 59;
									if (m == 0) begin
										m = 59;
										if (h > 0) h = h - 1;
									end else begin
										m = m - 1;
									end
								end else begin
									s = s - 1;
								end
							end
						end else begin
							halted_q = 1'b1;
							w.expd = 1'b1;
						end
					end
					hr_st[0] = h[HOUR_W-1:0];
					mn_st[0] = m[MIN_W-1:0];
					sc_st[0] = s[SEC_W-1:0];
					sb_st[0] = t[SUB_W-1:0];
					if (cfg_q.display_enable) begin
						if (cfg_q.display_format) begin
							a = m;
							b = s;
							c = hund_value(sb_st[0]);
						end else begin
							a = h;
							b = m;
							c = s;
						end
						w.digit[5] = 4'(a / 10);
						w.digit[4] = 4'(a % 10);
						w.digit[3] = 4'(b / 10);
						w.digit[2] = 4'(b % 10);
						w.digit[1] = 4'(c / 10);
						w.digit[0] = 4'(c % 10);
						w.upd = 1'b1;
					end
				end
			end
			FN_START: begin
				halted_q = 1'b0;
				run_q = 1'b1;
			end
			FN_STOP: run_q = 1'b0;
			FN_CLEAR: timer_reset();
			FN_SAVE: begin
				if (ok && sl != 0) begin
					hr_st[sl] = hr_st[0];
					mn_st[sl] = mn_st[0];
					sc_st[sl] = sc_st[0];
					sb_st[sl] = sb_st[0];
				end
			end
			FN_INC_H: if (ok) hr_st[sl] = 7'((int'(hr_st[sl]) + 1) % 100);
			FN_INC_M: if (ok) mn_st[sl] = 6'((int'(mn_st[sl]) + 1) % 60);
			FN_INC_S: if (ok) sc_st[sl] = 6'((int'(sc_st[sl]) + 1) % 60);
			default: ;
		endcase
		if (ok) begin
			w.hour = hr_st[sl];
			w.minute = mn_st[sl];
			w.second = sc_st[sl];
			w.hund = 7'(hund_value(sb_st[sl]));
		end
		return w;
	endfunction

	function automatic timer_word_t unpack_word(input logic [OUT_W-1:0] d);
		timer_word_t u;
		u.hour = d[6:0];
		u.minute = d[12:7];
		u.second = d[18:13];
		u.hund = d[25:19];
		for (int k = 0; k < N_DIGITS; k++) u.digit[N_DIGITS-1-k] = d[26+4*k +: 4];
		u.upd = d[50];
		u.expd = d[51];
		return u;
	endfunction

	// mirror the block on every accepted word and check results in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_COUNT_DOWN: cfg_q.count_down = cfg_data;
					REG_DISP_EN:    cfg_q.display_enable = cfg_data;
					REG_DISP_FMT:   cfg_q.display_format = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pred_w = timer_step(s_axis_tdata[3:0], s_axis_tdata[5:4]);
				if (cur_known == KNOWN_ZERO) begin
					pred_w = '0;
				end else if (cur_known == KNOWN_EXPIRY) begin
					pred_w = '0;
					pred_w.upd = 1'b1;
					pred_w.expd = 1'b1;
				end
				expected_words.push_back(pred_w);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_w = unpack_word(m_axis_tdata);
				if (expected_words.size() == 0) begin
					if (errors < 10)
						$display("unexpected word: h=%0d m=%0d s=%0d hu=%0d d=%h upd=%b exp=%b",
							got_w.hour, got_w.minute, got_w.second, got_w.hund, got_w.digit,
							got_w.upd, got_w.expd);
					errors++;
				end else begin
					exp_w = expected_words.pop_front();
					if (got_w.hour !== exp_w.hour || got_w.minute !== exp_w.minute ||
							got_w.second !== exp_w.second || got_w.hund !== exp_w.hund ||
							got_w.digit !== exp_w.digit || got_w.upd !== exp_w.upd ||
							got_w.expd !== exp_w.expd) begin
						if (errors < 10)
							$display("mismatch: expected h=%0d m=%0d s=%0d hu=%0d d=%h upd=%b exp=%b, %s",
								exp_w.hour, exp_w.minute, exp_w.second, exp_w.hund, exp_w.digit,
								exp_w.upd, exp_w.expd,
								$sformatf("got h=%0d m=%0d s=%0d hu=%0d d=%h upd=%b exp=%b",
								got_w.hour, got_w.minute, got_w.second, got_w.hund, got_w.digit,
								got_w.upd, got_w.expd));
						errors++;
					end
				end
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		rx_phase <= rx_phase + 4'd1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:    m_axis_tready <= 1'b1;
			RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
			RX_QUARTER: m_axis_tready <= (rx_phase[1:0] == 2'd0);
			default:    m_axis_tready <= rx_phase[3];
		endcase
	end

	initial begin
		wait (arst_n);
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("stopwatch_countdown_timer verification failed");
		$finish;
	end

	task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [1:0] sl, input known_t k);
		cur_known = k;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, sl, fn};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		cur_known = KNOWN_NONE;
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c, input logic stray);
		wait_drained();
		cfg_write(REG_COUNT_DOWN, c.count_down);
		cfg_write(REG_DISP_EN, c.display_enable);
		cfg_write(REG_DISP_FMT, c.display_format);
		if (stray) cfg_write(REG_NONE, 1'($urandom_range(0, 1)));
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic pick_cmd(output logic [FUNC_W-1:0] fn, output logic [1:0] sl);
		int r;
		r = $urandom_range(0, 99);
		sl = 2'($urandom_range(0, 3));
		if (r < 45) fn = FN_TICK;
		else if (r < 52) fn = FN_INC_S;
		else if (r < 58) fn = FN_INC_M;
		else if (r < 63) fn = FN_INC_H;
		else if (r < 69) fn = FN_START;
		else if (r < 72) fn = FN_STOP;
		else if (r < 78) fn = FN_SAVE;
		else if (r < 86) fn = FN_READ;
		else if (r < 87) fn = FN_CLEAR;
		else if (r < 90) fn = 4'($urandom_range(FN_ODD_LO, FN_ODD_HI));
		else fn = FN_TICK;
		if (fn inside {FN_INC_H, FN_INC_M, FN_INC_S} && $urandom_range(0, 1) == 0) sl = 2'd0;
	endtask

	function automatic void add_row(input logic apply, input cfg_t c, input logic [FUNC_W-1:0] fn,
			input logic [1:0] sl, input known_t k);
		cmd_rows.push_back('{apply, c, fn, sl, k});
	endfunction

	initial begin
		cmd_row_t    row;
		cfg_t        c;
		logic [FUNC_W-1:0] fn;
		logic [1:0]  sl;
		timer_reset();
		cfg_q = '0;

		// up mode, display off
		add_row(1'b1, 3'b000, FN_READ,   2'd0, KNOWN_ZERO);
		add_row(1'b0, 3'b000, FN_READ,   2'd3, KNOWN_ZERO);
		add_row(1'b0, 3'b000, FN_TICK,   2'd0, KNOWN_ZERO);
		add_row(1'b0, 3'b000, FN_INC_H,  2'd3, KNOWN_ZERO);
		add_row(1'b0, 3'b000, FN_INC_H,  2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_INC_M,  2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_INC_S,  2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_SAVE,   2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_SAVE,   2'd1, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_SAVE,   2'd3, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_START,  2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_TICK,   2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_ODD_HI, 2'd1, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_ODD_LO, 2'd2, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_STOP,   2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_TICK,   2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b000, FN_CLEAR,  2'd1, KNOWN_ZERO);
		// down mode, display on, minutes seconds hundredths
		add_row(1'b1, 3'b111, FN_START,  2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b111, FN_TICK,   2'd0, KNOWN_EXPIRY);
		add_row(1'b0, 3'b111, FN_TICK,   2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b111, FN_INC_S,  2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b111, FN_TICK,   2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b111, FN_START,  2'd2, KNOWN_NONE);
		add_row(1'b0, 3'b111, FN_TICK,   2'd0, KNOWN_NONE);
		add_row(1'b0, 3'b111, FN_READ,   2'd0, KNOWN_NONE);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (cmd_rows[i]) begin
			row = cmd_rows[i];
			if (row.apply) apply_cfg(row.cfg, 1'b0);
			send_word(row.fn, row.sl, row.known);
			pace();
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) c = 3'b000;
			else if (p == 1) c = 3'b111;
			else c = cfg_t'($urandom_range(0, 7));
			apply_cfg(c, p == 2);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 3 && n == 100) wait_drained();
				pick_cmd(fn, sl);
				send_word(fn, sl, KNOWN_NONE);
				pace();
			end
		end

		wait_drained();
		repeat (10) @(negedge clk);
		if (errors == 0) begin
			$display("stopwatch_countdown_timer verification clean");
		end else begin
			$display("stopwatch_countdown_timer verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
src/stc_pkg.sv
src/stc_digits.sv
src/stc_state.sv
src/stopwatch_countdown_timer.sv
bench/testbench.sv
